// ===== rtl/npc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Near palindrome checker package
// Shared request and result types and the default buffer size.
// ----------------------------------------------------------------------------
package npc_pkg;

  localparam int unsigned MaxLenDefault = 1024;

  typedef struct packed {
    logic [7:0] char_in;
    logic       is_last;
  } in_req_t;

  typedef struct packed {
    logic near_palindrome;
    logic overflow;
  } out_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/near_palindrome_checker_unit.sv =====
// While loading, one byte request is taken per cycle. After the last byte, each
// compared pair goes through a memory read state and then a compare state.
// The block checks one string at a time and takes no new byte until the
// result request is issued.
// Reset clears the control state only; the byte buffer is not cleared.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Near palindrome checker
// Buffers a byte string in a dual-read memory and checks whether deleting at
// most one byte leaves a palindrome, with one left-skip and one right-skip retry.
// ----------------------------------------------------------------------------
module near_palindrome_checker_unit #(
  parameter int unsigned MAX_LEN = npc_pkg::MaxLenDefault
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire npc_pkg::in_req_t  in_req_i,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output npc_pkg::out_rsp_t    out_rsp_o
);

  localparam int unsigned AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int unsigned LW = $clog2(MAX_LEN + 1);

  typedef enum logic [3:0] {
    StLoad = 4'b0001,
    StRead = 4'b0010,
    StCmp  = 4'b0100,
    StFin  = 4'b1000
  } state_e;

  typedef enum logic [1:0] {
    PhMain  = 2'd0,
    PhLeft  = 2'd1,
    PhRight = 2'd2
  } phase_e;

  logic [7:0] mem [MAX_LEN];

  state_e            state_q, state_d;
  phase_e            phase_q, phase_d;
  logic [LW-1:0]     len_q, len_d;
  logic              ov_q, ov_d;
  logic [AW-1:0]     lo_q, lo_d, hi_q, hi_d;
  logic [AW-1:0]     mlo_q, mlo_d, mhi_q, mhi_d;
  logic              res_q, res_d;
  logic              out_valid_q, out_valid_d;
  npc_pkg::out_rsp_t out_rsp_q, out_rsp_d;
  logic [7:0]        rd_lo_q, rd_hi_q;

  logic          in_acc;
  logic          full;
  logic          wr_en;
  logic [LW-1:0] len_eff;
  logic          out_free;

  assign in_stall_o = (state_q != StLoad);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign full       = (len_q == LW'(MAX_LEN));
  assign wr_en      = in_acc && !full;
  assign len_eff    = full ? len_q : len_q + LW'(1);
  assign out_free   = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[len_q[AW-1:0]] <= in_req_i.char_in;
    end
    rd_lo_q <= mem[lo_q];
    rd_hi_q <= mem[hi_q];
  end

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    len_d       = len_q;
    ov_d        = ov_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mlo_d       = mlo_q;
    mhi_d       = mhi_q;
    res_d       = res_q;
    out_rsp_d   = out_rsp_q;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      StLoad: begin
        if (in_acc) begin
          len_d = len_eff;
          if (full) begin
            ov_d = 1'b1;
          end
          if (in_req_i.is_last) begin
            lo_d    = '0;
            hi_d    = AW'(len_eff - LW'(1));
            phase_d = PhMain;
            if (len_eff < LW'(2)) begin
              res_d   = 1'b1;
              state_d = StFin;
            end else begin
              state_d = StRead;
            end
          end
        end
      end
      StRead: begin
        if (lo_q < hi_q) begin
          state_d = StCmp;
        end else begin
          res_d   = 1'b1;
          state_d = StFin;
        end
      end
      StCmp: begin
        state_d = StRead;
        if (rd_lo_q == rd_hi_q) begin
          lo_d = lo_q + AW'(1);
          hi_d = hi_q - AW'(1);
        end else begin
          case (phase_q)
            PhMain: begin
              mlo_d   = lo_q;
              mhi_d   = hi_q;
              lo_d    = lo_q + AW'(1);
              phase_d = PhLeft;
            end
            PhLeft: begin
              lo_d    = mlo_q;
              hi_d    = mhi_q - AW'(1);
              phase_d = PhRight;
            end
            default: begin
              res_d   = 1'b0;
              state_d = StFin;
            end
          endcase
        end
      end
      StFin: begin
        if (out_free) begin
          out_valid_d               = 1'b1;
          out_rsp_d.near_palindrome = res_q;
          out_rsp_d.overflow        = ov_q;
          len_d                     = '0;
          ov_d                      = 1'b0;
          phase_d                   = PhMain;
          state_d                   = StLoad;
        end
      end
      default: begin
        state_d = StLoad;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StLoad;
      phase_q     <= PhMain;
      len_q       <= '0;
      ov_q        <= 1'b0;
      lo_q        <= '0;
      hi_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      len_q       <= len_d;
      ov_q        <= ov_d;
      lo_q        <= lo_d;
      hi_q        <= hi_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mlo_q     <= mlo_d;
    mhi_q     <= mhi_d;
    res_q     <= res_d;
    out_rsp_q <= out_rsp_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule

`default_nettype wire

// ===== rtl/npc_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Near palindrome checker port checker
// Watches the ports of the top level and flags handshake and sequencing slips.
// ----------------------------------------------------------------------------
module npc_checker (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_stall_o,
  input wire npc_pkg::in_req_t  in_req_i,
  input wire logic              out_valid_o,
  input wire logic              out_stall_i,
  input wire npc_pkg::out_rsp_t out_rsp_o
);

  // A stalled result request holds its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("result request changed while stalled");

  // Once the last byte is taken, the block is busy checking.
  a_last_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_req_i.is_last |=> in_stall_o)
    else $error("byte taken right after the last byte of a string");

  // A new result only appears at the end of a check.
  a_result_after_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without a finished check");

  // While a string is still loading, no second result shows up.
  a_no_result_in_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o && !in_stall_o |=> !out_valid_o)
    else $error("result appeared while loading");

endmodule

bind near_palindrome_checker_unit npc_checker u_npc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_req_i    (in_req_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_rsp_o   (out_rsp_o)
);

`default_nettype wire
